// ===== rtl/assert_macros.svh =====
// assertion helpers, sampled on clk, disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define RAU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define RAU_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/rau_pkg.sv =====
`default_nettype none

package rau_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FIELD_W        = 32;
	localparam int CMD_W          = 3;

	localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LT   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_GT   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_EQ   = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD = 3'd7;

	typedef enum logic [1:0] {
		MSEL_P0,
		MSEL_P1,
		MSEL_P2
	} msel_t;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_DECODE = 9'b000000010,
		ST_GCD    = 9'b000000100,
		ST_DIVA   = 9'b000001000,
		ST_DIVB   = 9'b000010000,
		ST_MUL0   = 9'b000100000,
		ST_MUL1   = 9'b001000000,
		ST_MUL2   = 9'b010000000,
		ST_FINISH = 9'b100000000
	} state_t;

	typedef struct packed {
		logic       load;
		logic       gcd_step;
		logic       div_load_a;
		logic       div_load_b;
		logic       div_step;
		logic       qa_save;
		logic       qb_save;
		logic       mul_en;
		msel_t      mul_sel;
		logic       finish;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             den_zero;
		logic             den_eq;
		logic             gcd_done;
		logic             div_done;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/rau_ctrl.sv =====
`default_nettype none

module rau_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rau_pkg::dp_sts_t  sts,
	output rau_pkg::dp_cmd_t  dcmd
);

`include "assert_macros.svh"

	rau_pkg::state_t state_q;
	rau_pkg::state_t state_nx;
	logic            addsub;

	assign addsub = (sts.cmd == rau_pkg::CMD_ADD) || (sts.cmd == rau_pkg::CMD_SUB);
	assign busy   = (state_q != rau_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rau_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx     = state_q;
		dcmd         = '0;
		dcmd.mul_sel = rau_pkg::MSEL_P0;
		unique case (state_q)
			rau_pkg::ST_IDLE: begin
				if (start) begin
					dcmd.load = 1'b1;
					state_nx  = rau_pkg::ST_DECODE;
				end
			end
			rau_pkg::ST_DECODE: begin
				if (sts.cmd == rau_pkg::CMD_RSVD || sts.den_zero || (addsub && sts.den_eq)) begin
					state_nx = rau_pkg::ST_FINISH;
				end else if (addsub) begin
					state_nx = rau_pkg::ST_GCD;
				end else begin
					state_nx = rau_pkg::ST_MUL0;
				end
			end
			rau_pkg::ST_GCD: begin
				if (sts.gcd_done) begin
					dcmd.div_load_a = 1'b1;
					state_nx        = rau_pkg::ST_DIVA;
				end else begin
					dcmd.gcd_step = 1'b1;
				end
			end
			rau_pkg::ST_DIVA: begin
				if (sts.div_done) begin
					dcmd.qa_save    = 1'b1;
					dcmd.div_load_b = 1'b1;
					state_nx        = rau_pkg::ST_DIVB;
				end else begin
					dcmd.div_step = 1'b1;
				end
			end
			rau_pkg::ST_DIVB: begin
				if (sts.div_done) begin
					dcmd.qb_save = 1'b1;
					state_nx     = rau_pkg::ST_MUL0;
				end else begin
					dcmd.div_step = 1'b1;
				end
			end
			rau_pkg::ST_MUL0: begin
				dcmd.mul_en  = 1'b1;
				dcmd.mul_sel = rau_pkg::MSEL_P0;
				state_nx     = rau_pkg::ST_MUL1;
			end
			rau_pkg::ST_MUL1: begin
				dcmd.mul_en  = 1'b1;
				dcmd.mul_sel = rau_pkg::MSEL_P1;
				state_nx     = addsub ? rau_pkg::ST_MUL2 : rau_pkg::ST_FINISH;
			end
			rau_pkg::ST_MUL2: begin
				dcmd.mul_en  = 1'b1;
				dcmd.mul_sel = rau_pkg::MSEL_P2;
				state_nx     = rau_pkg::ST_FINISH;
			end
			rau_pkg::ST_FINISH: begin
				dcmd.finish = 1'b1;
				state_nx    = rau_pkg::ST_IDLE;
			end
			default: begin
				state_nx = rau_pkg::ST_IDLE;
			end
		endcase
	end

	// result strobe is never high on consecutive clocks
	`RAU_ASSERT_NEXT(a_finish_single, dcmd.finish, !dcmd.finish, "finish held two cycles")
	// multiplies never start on a zero denominator
	`RAU_ASSERT(a_mul_den_ok, (state_q != rau_pkg::ST_MUL0) || !sts.den_zero, "multiply with zero denominator")
	// gcd only runs for add and subtract
	`RAU_ASSERT(a_gcd_addsub, (state_q != rau_pkg::ST_GCD) || addsub, "gcd for non add/sub operation")

endmodule

`default_nettype wire

// ===== rtl/rau_dp.sv =====
`default_nettype none

module rau_dp #(
	parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rau_pkg::dp_cmd_t               dcmd,
	output rau_pkg::dp_sts_t               sts,
	input  logic [rau_pkg::CMD_W-1:0]      cmd,
	input  logic signed [rau_pkg::FIELD_W-1:0] num_a,
	input  logic signed [rau_pkg::FIELD_W-1:0] den_a,
	input  logic signed [rau_pkg::FIELD_W-1:0] num_b,
	input  logic signed [rau_pkg::FIELD_W-1:0] den_b,
	output logic                           done,
	output logic signed [rau_pkg::FIELD_W-1:0] res_num,
	output logic signed [rau_pkg::FIELD_W-1:0] res_den,
	output logic                           res_flag,
	output logic                           status
);

	localparam int W  = DATA_WIDTH;
	localparam int FW = rau_pkg::FIELD_W;
	localparam int CW = $clog2(W + 1);
	localparam int KW = $clog2(W);

	logic [rau_pkg::CMD_W-1:0] cmd_q;
	logic signed [W-1:0]       na_q, da_q, nb_q, db_q;
	logic [W-1:0]              ma_q, mb_q;
	logic [W-1:0]              u_q, v_q;
	logic [KW-1:0]             k_q;
	logic [W-1:0]              rem_q, quo_q, dsr_q;
	logic [CW-1:0]             cnt_q;
	logic [W-1:0]              qa_q, qb_q;
	logic signed [2*W-1:0]     prod0_q, prod1_q;
	logic [W-1:0]              prod2_q;
	logic signed [W-1:0]       rn_q, rd_q;
	logic                      fl_q, st_q, done_q;

	logic [W-1:0]              da_in, db_in, abs_da, abs_db;
	logic [W-1:0]              u_nx, v_nx;
	logic [KW-1:0]             k_nx;
	logic [W:0]                trial;
	logic [W-1:0]              rem_nx, quo_nx;
	logic signed [W-1:0]       mop_a, mop_b;
	logic signed [2*W-1:0]     mprod;
	logic                      addsub, is_mul, den_zero;
	logic [W-1:0]              ta, tb;
	logic                      p_lt, p_eq, sgn_neg, lt, gt;
	logic [W-1:0]              rn, rd;
	logic                      fl, st;

	assign da_in  = den_a[W-1:0];
	assign db_in  = den_b[W-1:0];
	assign abs_da = da_in[W-1] ? (~da_in + W'(1)) : da_in;
	assign abs_db = db_in[W-1] ? (~db_in + W'(1)) : db_in;

	assign addsub   = (cmd_q == rau_pkg::CMD_ADD) || (cmd_q == rau_pkg::CMD_SUB);
	assign is_mul   = (cmd_q == rau_pkg::CMD_MUL);
	assign den_zero = (da_q == '0) || (db_q == '0);

	assign sts.cmd      = cmd_q;
	assign sts.den_zero = den_zero;
	assign sts.den_eq   = (da_q == db_q);
	assign sts.gcd_done = (u_q == v_q);
	assign sts.div_done = (cnt_q == CW'(W));

	// binary gcd step, common powers of two counted in k
	always_comb begin
		u_nx = u_q;
		v_nx = v_q;
		k_nx = k_q;
		priority if (u_q == v_q) begin
			u_nx = u_q;
		end else if (!u_q[0] && !v_q[0]) begin
			u_nx = u_q >> 1;
			v_nx = v_q >> 1;
			k_nx = k_q + KW'(1);
		end else if (!u_q[0]) begin
			u_nx = u_q >> 1;
		end else if (!v_q[0]) begin
			v_nx = v_q >> 1;
		end else if (u_q > v_q) begin
			u_nx = (u_q - v_q) >> 1;
		end else begin
			v_nx = (v_q - u_q) >> 1;
		end
	end

	// restoring divider, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[W-1]} - {1'b0, dsr_q};
		if (!trial[W]) begin
			rem_nx = trial[W-1:0];
			quo_nx = {quo_q[W-2:0], 1'b1};
		end else begin
			rem_nx = {rem_q[W-2:0], quo_q[W-1]};
			quo_nx = {quo_q[W-2:0], 1'b0};
		end
	end

	always_comb begin
		mop_a = na_q;
		mop_b = db_q;
		unique case (dcmd.mul_sel)
			rau_pkg::MSEL_P0: begin
				mop_a = na_q;
				mop_b = addsub ? signed'(qb_q) : (is_mul ? nb_q : db_q);
			end
			rau_pkg::MSEL_P1: begin
				mop_a = addsub ? nb_q : da_q;
				mop_b = addsub ? signed'(qa_q) : (is_mul ? db_q : nb_q);
			end
			rau_pkg::MSEL_P2: begin
				mop_a = signed'(qa_q);
				mop_b = signed'(mb_q);
			end
			default: begin
				mop_a = na_q;
				mop_b = db_q;
			end
		endcase
	end

	assign mprod = (2*W)'(mop_a) * (2*W)'(mop_b);

	assign ta      = da_q[W-1] ? (W'(0) - prod0_q[W-1:0]) : prod0_q[W-1:0];
	assign tb      = db_q[W-1] ? (W'(0) - prod1_q[W-1:0]) : prod1_q[W-1:0];
	assign p_lt    = (prod0_q < prod1_q);
	assign p_eq    = (prod0_q == prod1_q);
	assign sgn_neg = da_q[W-1] ^ db_q[W-1];
	assign lt      = sgn_neg ? (!p_lt && !p_eq) : p_lt;
	assign gt      = sgn_neg ? p_lt : (!p_lt && !p_eq);

	always_comb begin
		rn = '0;
		rd = '0;
		fl = 1'b0;
		st = 1'b0;
		if (den_zero && cmd_q != rau_pkg::CMD_RSVD) begin
			st = 1'b1;
		end else begin
			unique case (cmd_q)
				rau_pkg::CMD_ADD: begin
					rn = sts.den_eq ? W'(na_q + nb_q) : (ta + tb);
					rd = sts.den_eq ? da_q : prod2_q;
				end
				rau_pkg::CMD_SUB: begin
					rn = sts.den_eq ? W'(na_q - nb_q) : (ta - tb);
					rd = sts.den_eq ? da_q : prod2_q;
				end
				rau_pkg::CMD_MUL, rau_pkg::CMD_DIV: begin
					rn = prod0_q[W-1:0];
					rd = prod1_q[W-1:0];
				end
				rau_pkg::CMD_LT: fl = lt;
				rau_pkg::CMD_GT: fl = gt;
				rau_pkg::CMD_EQ: fl = p_eq;
				default: begin
					st = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= dcmd.finish;
			if (dcmd.div_load_a || dcmd.div_load_b) begin
				cnt_q <= '0;
			end else if (dcmd.div_step) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			cmd_q <= cmd;
			na_q  <= num_a[W-1:0];
			da_q  <= da_in;
			nb_q  <= num_b[W-1:0];
			db_q  <= db_in;
			ma_q  <= abs_da;
			mb_q  <= abs_db;
			u_q   <= abs_da;
			v_q   <= abs_db;
			k_q   <= '0;
		end else if (dcmd.gcd_step) begin
			u_q <= u_nx;
			v_q <= v_nx;
			k_q <= k_nx;
		end
		if (dcmd.div_load_a) begin
			quo_q <= ma_q;
			rem_q <= '0;
			dsr_q <= u_q << k_q;
		end else if (dcmd.div_load_b) begin
			quo_q <= mb_q;
			rem_q <= '0;
		end else if (dcmd.div_step) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
		if (dcmd.qa_save) begin
			qa_q <= quo_q;
		end
		if (dcmd.qb_save) begin
			qb_q <= quo_q;
		end
		if (dcmd.mul_en) begin
			unique case (dcmd.mul_sel)
				rau_pkg::MSEL_P0: prod0_q <= mprod;
				rau_pkg::MSEL_P1: prod1_q <= mprod;
				rau_pkg::MSEL_P2: prod2_q <= mprod[W-1:0];
				default: prod2_q <= prod2_q;
			endcase
		end
		if (dcmd.finish) begin
			rn_q <= rn;
			rd_q <= rd;
			fl_q <= fl;
			st_q <= st;
		end
	end

	assign done     = done_q;
	assign res_num  = FW'(rn_q);
	assign res_den  = FW'(rd_q);
	assign res_flag = fl_q;
	assign status   = st_q;

endmodule

`default_nettype wire

// ===== rtl/rational_arithmetic_unit.sv =====
// channel   direction  ports                                   transfer
// command   in         start, busy, cmd, num_a, den_a,         start high, busy low
//                      num_b, den_b
// result    out        done, res_num, res_den, res_flag,       done high, one cycle
//                      status
//
// add/sub with unequal denominators: binary gcd, two restoring divisions, three
//   multiplies; mul, div and compares use two multiplies; errors go straight
//   to the result
// one shared multiplier and one divider, items are worked one at a time
// arst_n clears the controller and the result strobe
// the receiver cannot stall; a new command is taken in the cycle done is shown
`default_nettype none

module rational_arithmetic_unit #(
	parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [rau_pkg::CMD_W-1:0]          cmd,
	input  logic signed [rau_pkg::FIELD_W-1:0] num_a,
	input  logic signed [rau_pkg::FIELD_W-1:0] den_a,
	input  logic signed [rau_pkg::FIELD_W-1:0] num_b,
	input  logic signed [rau_pkg::FIELD_W-1:0] den_b,
	output logic                               done,
	output logic signed [rau_pkg::FIELD_W-1:0] res_num,
	output logic signed [rau_pkg::FIELD_W-1:0] res_den,
	output logic                               res_flag,
	output logic                               status
);

	rau_pkg::dp_cmd_t dcmd;
	rau_pkg::dp_sts_t sts;

	rau_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.dcmd   (dcmd)
	);

	rau_dp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.dcmd     (dcmd),
		.sts      (sts),
		.cmd      (cmd),
		.num_a    (num_a),
		.den_a    (den_a),
		.num_b    (num_b),
		.den_b    (den_b),
		.done     (done),
		.res_num  (res_num),
		.res_den  (res_den),
		.res_flag (res_flag),
		.status   (status)
	);

endmodule

`default_nettype wire
